### design/config_text_tokenizer_assert.svh
// Assertion macros for the tokenizer modules; only cfg_tok_back uses them.
// Needs only a clock and an active-low reset in the scope of each use.
`ifndef CONFIG_TEXT_TOKENIZER_ASSERT_SVH
`define CONFIG_TEXT_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define TOK_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");

// Next-cycle implication, disabled while reset is held.
`define TOK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");

`endif

### design/cfg_tok_pkg.sv
// Package for the configuration text tokenizer: character codes, classifiers,
// the queue entry type and queue status. No dependencies.
`timescale 1ns / 1ps

package cfg_tok_pkg;

  localparam int LINE_BITS_DEF = 32;
  localparam int LINE_NUM_W    = 32;
  localparam int Q_DEPTH       = 4;   // must be a power of two
  localparam int Q_AW          = $clog2(Q_DEPTH);
  localparam int Q_CW          = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  // One queue entry holds every result of one input word. A pair entry means
  // a bare token end followed by the special byte as a one-byte token.
  typedef struct packed {
    logic [LINE_NUM_W-1:0] line;
    logic [7:0]            tbyte;
    logic                  has_byte;
    logic                  token_end;
    logic                  quote_err;
    logic                  pair;
  } cfg_tok_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } cfg_tok_qstat_t;

  function automatic logic is_white(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB);
  endfunction

  function automatic logic is_quote(input logic [7:0] c);
    return (c == CH_DQUOTE) || (c == CH_SQUOTE);
  endfunction

  function automatic logic is_comment(input logic [7:0] c);
    return (c == CH_HASH) || (c == CH_SEMI);
  endfunction

  function automatic logic is_special(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_EQUAL) ||
           (c == CH_LBRACE) || (c == CH_RBRACE) ||
           (c == CH_LBRACK) || (c == CH_RBRACK);
  endfunction

endpackage

### design/config_text_tokenizer.sv
// Configuration text tokenizer. An accepted word passes through the queue into the
// output register. Throughput: one input word per cycle while the queue has room and
// one result word per cycle while the output is not stalled; a word with two results
// holds the output for both, which the four-entry queue hides only in short bursts.
// Reset (synchronous, active low) clears the lexer flags, sets the line count to one
// and empties the queue and the output register; nothing else needs clearing.
`timescale 1ns / 1ps

module config_text_tokenizer #(
  parameter int LINE_BITS = cfg_tok_pkg::LINE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_text_byte,
  input  logic                               in_end_of_input,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_token_byte,
  output logic                               out_has_byte,
  output logic                               out_token_end,
  output logic [cfg_tok_pkg::LINE_NUM_W-1:0] out_line_number,
  output logic                               out_quote_error,
  output logic                               out_last_of_run
);
  import cfg_tok_pkg::*;

  // The front classifies every accepted word in the cycle it arrives and
  // updates the token, comment and quote flags and the saturating line
  // counter. Every word that yields results becomes one queue entry, so the
  // front stalls only when the queue is full.
  cfg_tok_entry_t push_entry;
  cfg_tok_entry_t head;
  cfg_tok_qstat_t q_stat;
  logic           push;
  logic           pop;

  cfg_tok_front #(
    .LINE_BITS(LINE_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_text_byte   (in_text_byte),
    .in_end_of_input(in_end_of_input),
    .q_stat         (q_stat),
    .push           (push),
    .push_entry     (push_entry)
  );

  // The queue decouples the two sides so that a stalled output does not
  // immediately stall the input.
  cfg_tok_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // The back end splits a pair entry into a token end and a one-byte token
  // and flags the final result word of each input word.
  cfg_tok_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_stat         (q_stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_token_byte (out_token_byte),
    .out_has_byte   (out_has_byte),
    .out_token_end  (out_token_end),
    .out_line_number(out_line_number),
    .out_quote_error(out_quote_error),
    .out_last_of_run(out_last_of_run)
  );

endmodule

### design/cfg_tok_front.sv
// Front end of the tokenizer: accepts input words, classifies each byte,
// keeps the lexer flags and line counter, and builds queue entries. Uses cfg_tok_pkg.
`timescale 1ns / 1ps

module cfg_tok_front #(
  parameter int LINE_BITS = cfg_tok_pkg::LINE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_text_byte,
  input  logic                        in_end_of_input,
  input  cfg_tok_pkg::cfg_tok_qstat_t q_stat,
  output logic                        push,
  output cfg_tok_pkg::cfg_tok_entry_t push_entry
);
  import cfg_tok_pkg::*;

  logic                 tok_r, tok_nxt;
  logic                 cmt_r, cmt_nxt;
  logic                 quo_r, quo_nxt;
  logic                 sgl_r, sgl_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic                 accept;
  logic                 has_res;
  logic                 sep;
  logic [7:0]           c;
  logic [7:0]           qch;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && has_res;
  assign c        = in_text_byte;

  always_comb begin
    tok_nxt    = tok_r;
    cmt_nxt    = cmt_r;
    quo_nxt    = quo_r;
    sgl_nxt    = sgl_r;
    line_nxt   = line_r;
    has_res    = 1'b0;
    push_entry = '0;
    sep        = is_white(c) || is_quote(c) || is_comment(c) || is_special(c);
    qch        = sgl_r ? CH_SQUOTE : CH_DQUOTE;

    if (!in_end_of_input && (c == CH_NL) && (line_r != {LINE_BITS{1'b1}})) begin
      line_nxt = line_r + LINE_BITS'(1);
    end
    push_entry.line = LINE_NUM_W'(line_nxt);

    if (in_end_of_input) begin
      if (quo_r) begin
        has_res              = 1'b1;
        push_entry.quote_err = 1'b1;
      end else if (tok_r) begin
        has_res              = 1'b1;
        push_entry.token_end = 1'b1;
      end
      tok_nxt = 1'b0;
      cmt_nxt = 1'b0;
      quo_nxt = 1'b0;
      sgl_nxt = 1'b0;
    end else if (quo_r) begin
      has_res = 1'b1;
      if (c == qch) begin
        push_entry.token_end = 1'b1;
        quo_nxt              = 1'b0;
        sgl_nxt              = 1'b0;
        tok_nxt              = 1'b0;
      end else begin
        push_entry.tbyte    = c;
        push_entry.has_byte = 1'b1;
      end
    end else if (cmt_r) begin
      if (c == CH_NL) begin
        cmt_nxt = 1'b0;
      end
    end else begin
      // A separator closes an open unquoted token before it is handled itself.
      if (sep && tok_r) begin
        has_res              = 1'b1;
        push_entry.token_end = 1'b1;
        tok_nxt              = 1'b0;
      end
      if (is_comment(c)) begin
        cmt_nxt = 1'b1;
      end else if (is_quote(c)) begin
        tok_nxt = 1'b1;
        quo_nxt = 1'b1;
        sgl_nxt = (c == CH_SQUOTE);
      end else if (is_special(c)) begin
        push_entry.pair      = tok_r;
        push_entry.tbyte     = c;
        push_entry.has_byte  = 1'b1;
        push_entry.token_end = 1'b1;
        has_res              = 1'b1;
      end else if (!is_white(c)) begin
        tok_nxt             = 1'b1;
        push_entry.tbyte    = c;
        push_entry.has_byte = 1'b1;
        has_res             = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= 1'b0;
      cmt_r  <= 1'b0;
      quo_r  <= 1'b0;
      sgl_r  <= 1'b0;
      line_r <= LINE_BITS'(1);
    end else if (accept) begin
      tok_r  <= tok_nxt;
      cmt_r  <= cmt_nxt;
      quo_r  <= quo_nxt;
      sgl_r  <= sgl_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

### design/cfg_tok_queue.sv
// Short first-in first-out queue of result entries between front and back.
// Uses cfg_tok_pkg for the entry type, depth and status struct.
`timescale 1ns / 1ps

module cfg_tok_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  cfg_tok_pkg::cfg_tok_entry_t push_entry,
  input  logic                        pop,
  output cfg_tok_pkg::cfg_tok_entry_t head,
  output cfg_tok_pkg::cfg_tok_qstat_t q_stat
);
  import cfg_tok_pkg::*;

  cfg_tok_entry_t  slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == Q_CW'(Q_DEPTH));
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + Q_CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers wrap on their own since the depth is a power of two.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### design/cfg_tok_back.sv
// Back end of the tokenizer: takes queue entries and presents one result word per
// cycle unless stalled, in an output register. Uses cfg_tok_pkg and the assert header.
`timescale 1ns / 1ps
`include "config_text_tokenizer_assert.svh"

module cfg_tok_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cfg_tok_pkg::cfg_tok_entry_t head,
  input  cfg_tok_pkg::cfg_tok_qstat_t q_stat,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_token_byte,
  output logic                        out_has_byte,
  output logic                        out_token_end,
  output logic [cfg_tok_pkg::LINE_NUM_W-1:0] out_line_number,
  output logic                        out_quote_error,
  output logic                        out_last_of_run
);
  import cfg_tok_pkg::*;

  logic                  valid_r, valid_nxt;
  logic                  phase_r, phase_nxt;
  logic [7:0]            byte_r, byte_nxt;
  logic                  has_r, has_nxt;
  logic                  end_r, end_nxt;
  logic [LINE_NUM_W-1:0] line_r, line_nxt;
  logic                  err_r, err_nxt;
  logic                  last_r, last_nxt;
  logic                  load;

  assign load = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    byte_nxt  = byte_r;
    has_nxt   = has_r;
    end_nxt   = end_r;
    line_nxt  = line_r;
    err_nxt   = err_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = !q_stat.empty;
      line_nxt  = head.line;
      err_nxt   = head.quote_err;
      if (head.pair && !phase_r) begin
        // First half of a pair: the bare end of the token before the byte.
        byte_nxt  = 8'h00;
        has_nxt   = 1'b0;
        end_nxt   = 1'b1;
        last_nxt  = 1'b0;
        phase_nxt = !q_stat.empty;
      end else begin
        byte_nxt  = head.tbyte;
        has_nxt   = head.has_byte;
        end_nxt   = head.token_end;
        last_nxt  = 1'b1;
        phase_nxt = 1'b0;
        pop       = !q_stat.empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    has_r  <= has_nxt;
    end_r  <= end_nxt;
    line_r <= line_nxt;
    err_r  <= err_nxt;
    last_r <= last_nxt;
  end

  assign out_valid       = valid_r;
  assign out_token_byte  = byte_r;
  assign out_has_byte    = has_r;
  assign out_token_end   = end_r;
  assign out_line_number = line_r;
  assign out_quote_error = err_r;
  assign out_last_of_run = last_r;

  `TOK_ASSERT_IMPL(a_pair_head_kept, clk, rst_n, phase_r, !q_stat.empty && head.pair)
  `TOK_ASSERT_IMPL(a_not_last_is_pair, clk, rst_n, valid_r && !last_r,
                   phase_r && end_r && !has_r && !err_r)
  `TOK_ASSERT_IMPL(a_err_alone, clk, rst_n, valid_r && err_r, !has_r && !end_r && last_r)
  `TOK_ASSERT_NEXT(a_pair_second, clk, rst_n, valid_r && !last_r && !out_stall,
                   valid_r && last_r && has_r && end_r)

endmodule

### test/config_text_tokenizer_test.sv
// Self-checking testbench for config_text_tokenizer: random and directed text words
// are checked against a built-in token predictor. It needs the RTL and cfg_tok_pkg.
`timescale 1ns / 1ps

module config_text_tokenizer_test;
  import cfg_tok_pkg::*;

  localparam int LINE_BITS   = LINE_BITS_DEF;
  localparam int HOLD_CYCLES = 300;

  // One result word as the block should present it.
  typedef struct {
    logic [7:0]            tbyte;
    logic                  has_byte;
    logic                  token_end;
    logic [LINE_NUM_W-1:0] line;
    logic                  quote_err;
    logic                  last;
  } tok_result_t;

  // The scoreboard keeps its own copy of the lexer state. Every accepted input
  // word is run through the predictor, and the results it yields wait in order
  // until the output monitor pops them.
  class token_scoreboard;
    bit                   in_token;
    bit                   in_comment;
    bit                   in_quote;
    bit                   single_quote;
    logic [LINE_BITS-1:0] line_count;
    tok_result_t          pending[$];
    int unsigned          errors;

    function new();
      in_token     = 0;
      in_comment   = 0;
      in_quote     = 0;
      single_quote = 0;
      line_count   = 1;
      errors       = 0;
    endfunction

    static function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_NL || c == CH_TAB;
    endfunction

    static function bit is_quote_ch(logic [7:0] c);
      return c == CH_DQUOTE || c == CH_SQUOTE;
    endfunction

    static function bit is_comment_ch(logic [7:0] c);
      return c == CH_HASH || c == CH_SEMI;
    endfunction

    static function bit is_special_ch(logic [7:0] c);
      return c == CH_PLUS || c == CH_MINUS || c == CH_EQUAL || c == CH_LBRACE ||
             c == CH_RBRACE || c == CH_LBRACK || c == CH_RBRACK;
    endfunction

    static function bit is_separator(logic [7:0] c);
      return is_blank(c) || is_quote_ch(c) || is_comment_ch(c) || is_special_ch(c);
    endfunction

    function tok_result_t make(logic [7:0] c, bit has, bit fin, bit err);
      tok_result_t r;
      r.tbyte     = has ? c : 8'h00;
      r.has_byte  = has;
      r.token_end = fin;
      r.line      = line_count[LINE_NUM_W-1:0];
      r.quote_err = err;
      r.last      = 1'b0;
      return r;
    endfunction

    function void note_word(logic [7:0] c, logic eoi);
      tok_result_t  run[$];
      logic [7:0]   closer;
      if (eoi) begin
        // End of text: an open quote is an error, an open token just closes.
        if (in_quote) run.push_back(make(8'h00, 0, 0, 1));
        else if (in_token) run.push_back(make(8'h00, 0, 1, 0));
        in_token     = 0;
        in_comment   = 0;
        in_quote     = 0;
        single_quote = 0;
      end else begin
        // Newlines count everywhere, inside quotes and comments too.
        if (c == CH_NL && line_count != {LINE_BITS{1'b1}}) line_count = line_count + 1;
        if (in_quote) begin
          closer = single_quote ? CH_SQUOTE : CH_DQUOTE;
          if (c == closer) begin
            run.push_back(make(8'h00, 0, 1, 0));
            in_quote     = 0;
            single_quote = 0;
            in_token     = 0;
          end else begin
            run.push_back(make(c, 1, 0, 0));
          end
        end else if (in_comment) begin
          if (c == CH_NL) in_comment = 0;
        end else begin
          if (is_separator(c) && in_token) begin
            run.push_back(make(8'h00, 0, 1, 0));
            in_token = 0;
          end
          if (is_comment_ch(c)) begin
            in_comment = 1;
          end else if (is_quote_ch(c)) begin
            in_token     = 1;
            in_quote     = 1;
            single_quote = (c == CH_SQUOTE);
          end else if (is_special_ch(c)) begin
            run.push_back(make(c, 1, 1, 0));
          end else if (!is_blank(c)) begin
            in_token = 1;
            run.push_back(make(c, 1, 0, 0));
          end
        end
      end
      if (run.size() > 0) run[run.size() - 1].last = 1'b1;
      foreach (run[i]) pending.push_back(run[i]);
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(tok_result_t got);
      tok_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, actual byte %0h has %0b end %0b line %0d err %0b",
                 $time, got.tbyte, got.has_byte, got.token_end, got.line, got.quote_err);
        errors++;
        return;
      end
      want = pending.pop_front();
      field_check("token_byte", want.tbyte, got.tbyte);
      field_check("has_byte", want.has_byte, got.has_byte);
      field_check("token_end", want.token_end, got.token_end);
      field_check("line_number", want.line, got.line);
      field_check("quote_error", want.quote_err, got.quote_err);
      field_check("last_of_run", want.last, got.last);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_text_byte = 8'h00;
  logic                  in_end_of_input = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_token_byte;
  logic                  out_has_byte;
  logic                  out_token_end;
  logic [LINE_NUM_W-1:0] out_line_number;
  logic                  out_quote_error;
  logic                  out_last_of_run;

  token_scoreboard sb = new();

  // Sender and receiver pacing, in percent of cycles.
  int idle_pct  = 0;
  int stall_pct = 0;
  // Each increment of the hold ticket asks the receiver for one long stall.
  int hold_ticket = 0;
  int hold_taken  = 0;
  int hold_left   = 0;
  int words_counted = 0;

  config_text_tokenizer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_text_byte    (in_text_byte),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_token_byte  (out_token_byte),
    .out_has_byte    (out_has_byte),
    .out_token_end   (out_token_end),
    .out_line_number (out_line_number),
    .out_quote_error (out_quote_error),
    .out_last_of_run (out_last_of_run)
  );

  always #5 clk = ~clk;

  // The receiver decides its stall at each falling edge. A pending hold
  // request wins over the random stall and keeps the output blocked long
  // enough for the internal queue to fill and push back on the sender.
  always @(negedge clk) begin
    if (hold_ticket != hold_taken) begin
      hold_taken <= hold_ticket;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Both monitors sample at the rising edge, so they see the values that
  // were settled before the block updates its registers.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_word(in_text_byte, in_end_of_input);
  end

  always @(posedge clk) begin
    tok_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.tbyte     = out_token_byte;
      got.has_byte  = out_has_byte;
      got.token_end = out_token_end;
      got.line      = out_line_number;
      got.quote_err = out_quote_error;
      got.last      = out_last_of_run;
      sb.check_result(got);
    end
  end

  // Offers one word, after a random number of idle cycles, and returns at
  // the falling edge after it was taken. Valid stays high on return, and the
  // next call or the end of the stimulus decides what it does next.
  task automatic send_word(input logic [7:0] b, input logic eoi, input bit counted);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_text_byte    <= b;
    in_end_of_input <= eoi;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
    if (counted) words_counted++;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (token_scoreboard::is_separator(b)) b = 8'($urandom_range(255));
    return b;
  endfunction

  function automatic logic [7:0] separator_byte();
    logic [7:0] seps[14];
    seps = '{CH_SPACE, CH_NL, CH_TAB, CH_DQUOTE, CH_SQUOTE, CH_HASH, CH_SEMI,
             CH_PLUS, CH_MINUS, CH_EQUAL, CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK};
    return seps[$urandom_range(13)];
  endfunction

  function automatic logic [7:0] special_byte();
    logic [7:0] specs[7];
    specs = '{CH_PLUS, CH_MINUS, CH_EQUAL, CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK};
    return specs[$urandom_range(6)];
  endfunction

  // Sends one piece of configuration text. Most pieces are well formed, so
  // the lexer walks through tokens, quotes and comments; the rest are raw
  // bytes, an unclosed quote or an early end of input.
  task automatic send_fragment();
    int         pick;
    int         n;
    logic [7:0] q;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 30) begin
      // Bare token, then whatever separator comes up.
      n = $urandom_range(6, 1);
      repeat (n) send_word(plain_byte(), 1'b0, 1);
      send_word(separator_byte(), 1'b0, 1);
    end else if (pick < 50) begin
      // Quoted token, possibly empty, possibly with newlines, now and then
      // left open so that later text falls into it.
      q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
      send_word(q, 1'b0, 1);
      n = $urandom_range(6);
      repeat (n) begin
        b = 8'($urandom_range(255));
        while (b == q) b = 8'($urandom_range(255));
        send_word(b, 1'b0, 1);
      end
      if ($urandom_range(9) != 0) send_word(q, 1'b0, 1);
    end else if (pick < 62) begin
      send_word(special_byte(), 1'b0, 1);
    end else if (pick < 72) begin
      // Comment: the block drops its body up to the newline.
      send_word($urandom_range(1) ? CH_HASH : CH_SEMI, 1'b0, 1);
      n = $urandom_range(5);
      repeat (n) begin
        b = 8'($urandom_range(255));
        while (b == CH_NL) b = 8'($urandom_range(255));
        send_word(b, 1'b0, 1);
      end
      send_word(CH_NL, 1'b0, 1);
    end else if (pick < 85) begin
      n = $urandom_range(3, 1);
      repeat (n) begin
        case ($urandom_range(2))
          0: send_word(CH_SPACE, 1'b0, 1);
          1: send_word(CH_NL, 1'b0, 1);
          default: send_word(CH_TAB, 1'b0, 1);
        endcase
      end
    end else if (pick < 88) begin
      // End of input carries a random byte that the block must ignore.
      send_word(8'($urandom_range(255)), 1'b1, 1);
    end else begin
      n = $urandom_range(4, 1);
      repeat (n) send_word(8'($urandom_range(255)), 1'b0, 1);
    end
  endtask

  task automatic run_phase(input int sender_idle, input int receiver_stall, input int count);
    int goal;
    goal      = words_counted + count;
    idle_pct  = sender_idle;
    stall_pct <= receiver_stall;
    while (words_counted < goal) send_fragment();
  endtask

  // Run limit well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("config_text_tokenizer verification failed");
    $finish;
  end

  initial begin
    int waited;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: byte extremes as token characters, a token ended by a
    // special byte (token end plus one-byte token), a single-quoted token with
    // an embedded double quote and a newline, an empty double-quoted token, a
    // comment that swallows text up to the newline, a comment start that ends a
    // token, a quote start that ends a token, end of input inside a quote,
    // inside a token and with nothing open.
    send_word(8'h00, 1'b0, 1);
    send_word(8'hFF, 1'b0, 1);
    send_word(CH_PLUS, 1'b0, 1);
    send_word(CH_SQUOTE, 1'b0, 1);
    send_word(CH_DQUOTE, 1'b0, 1);
    send_word(CH_NL, 1'b0, 1);
    send_word(CH_SQUOTE, 1'b0, 1);
    send_word(CH_DQUOTE, 1'b0, 1);
    send_word(CH_DQUOTE, 1'b0, 1);
    send_word(CH_HASH, 1'b0, 1);
    send_word("x", 1'b0, 1);
    send_word(CH_NL, 1'b0, 1);
    send_word("t", 1'b0, 1);
    send_word(CH_SEMI, 1'b0, 1);
    send_word(CH_NL, 1'b0, 1);
    send_word(CH_TAB, 1'b0, 1);
    send_word(CH_LBRACE, 1'b0, 1);
    send_word("q", 1'b0, 1);
    send_word(CH_DQUOTE, 1'b0, 1);
    send_word("z", 1'b0, 1);
    send_word(8'hFF, 1'b1, 1);
    send_word("k", 1'b0, 1);
    send_word(8'h00, 1'b1, 1);
    send_word(8'hA5, 1'b1, 1);
    send_word(CH_SPACE, 1'b0, 1);

    // Random part in pacing phases: free flow, a slow sender, a slow
    // receiver, then both mildly busy.
    run_phase(0, 0, 440);
    run_phase(69, 0, 440);
    run_phase(0, 69, 440);

    // Back pressure: the receiver blocks for a long stretch while the
    // sender keeps offering words at full rate.
    hold_ticket <= hold_ticket + 1;
    run_phase(0, 0, 120);

    run_phase(17, 17, 400);
    in_valid  <= 1'b0;
    stall_pct <= 0;

    // Drain everything that is still expected, then keep clocking the block
    // so that any surplus result would show.
    waited = 0;
    while (sb.pending.size() != 0 && waited < 50000) begin
      @(negedge clk);
      waited++;
    end
    repeat (20) @(negedge clk);

    if (sb.pending.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
    end
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("config_text_tokenizer verification clean");
    end else begin
      $display("config_text_tokenizer verification failed");
    end
    $finish;
  end

endmodule
